// ===== hw/rtl/tilt_shake_roll_gesture_detector_unit_defines.svh =====
// Assertion macros for the tilt, shake and roll gesture detector.
`ifndef TILT_SHAKE_ROLL_GESTURE_DETECTOR_UNIT_DEFINES_SVH
`define TILT_SHAKE_ROLL_GESTURE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSRGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSRGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tsrgd_pkg.sv =====
// Types and constants of the tilt, shake and roll gesture detector.
package tsrgd_pkg;

  // Input word: one three-axis sample
  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic [31:0]        now_ms;
    logic               clear_roll;
  } in_word_t;

  // Output word: one result per sample
  typedef struct packed {
    logic signed [7:0] scaled_x;
    logic signed [7:0] scaled_y;
    logic signed [7:0] scaled_z;
    logic signed [7:0] avg_x;
    logic signed [7:0] avg_y;
    logic signed [7:0] avg_z;
    logic [2:0]        tilt_new;
    logic [2:0]        tilt_positive;
    logic              shake_seen;
    logic [15:0]       roll_pattern;
    logic [3:0]        roll_length;
    logic              roll_ready;
  } out_word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } seq_state_e;

  // Per-axis tilt state
  typedef enum logic [1:0] {
    TILT_LEVEL,
    TILT_POS,
    TILT_NEG
  } tilt_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_CAL_X       = 3'd0;
  localparam logic [2:0] CFG_CAL_Y       = 3'd1;
  localparam logic [2:0] CFG_CAL_Z       = 3'd2;
  localparam logic [2:0] CFG_SHAKE_X     = 3'd3;
  localparam logic [2:0] CFG_SHAKE_Y     = 3'd4;
  localparam logic [2:0] CFG_SHAKE_Z     = 3'd5;
  localparam logic [2:0] CFG_TILT_ENTER  = 3'd6;
  localparam logic [2:0] CFG_TILT_LEAVE  = 3'd7;

  // Configuration reset values
  localparam logic [31:0] CAL_RESET        = 32'h7FFF_8000;
  localparam logic [15:0] SHAKE_RESET      = 16'h7B81;
  localparam logic [6:0]  TILT_ENTER_RESET = 7'd96;
  localparam logic [6:0]  TILT_LEAVE_RESET = 7'd32;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Scaling and timing constants
  localparam logic [7:0]        SCALE_SPAN       = 8'd250;
  localparam logic signed [8:0] SCALE_OFFSET     = 9'sd127;
  localparam logic [31:0]       ROLL_TIMEOUT_MS  = 32'd2000;
  localparam logic [31:0]       SHAKE_HOLDOFF_MS = 32'd500;
  localparam int unsigned       ROLL_READY_LEN   = 4;

  // Divide by ten: x * 6554 >> 16 is exact for x below 16384
  localparam logic [12:0] RECIP10       = 13'd6554;
  localparam int unsigned RECIP10_SHIFT = 16;

endpackage

// ===== hw/rtl/tilt_shake_roll_gesture_detector_unit.sv =====
// Top level of the tilt, shake and roll gesture detector.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o   | tsrgd_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i | tsrgd_pkg::out_word_t
//   cfg     | input     | cfg_we_i (no stall)       | cfg_idx_i, cfg_wdata_i
//
// Per axis a word passes a load state, the shared restoring divider and an update
// state; after the third axis an emit state writes the result into the output register.
// The next word is accepted once the result has gone into the output register.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds the result and the sequencer waits in its emit state.

`include "tilt_shake_roll_gesture_detector_unit_defines.svh"

module tilt_shake_roll_gesture_detector_unit #(
  parameter int unsigned ROLL_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tsrgd_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tsrgd_pkg::out_word_t out_word_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);

  localparam int unsigned SLOT_W = 2 * ROLL_DEPTH;
  localparam int unsigned CNT_W  = $clog2(ROLL_DEPTH + 1);

  // Configuration registers
  logic [31:0] cal_q   [3];
  logic [15:0] bounds_q[3];
  logic [6:0]  enter_q;
  logic [6:0]  leave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cal_q[i]    <= tsrgd_pkg::CAL_RESET;
        bounds_q[i] <= tsrgd_pkg::SHAKE_RESET;
      end
      enter_q <= tsrgd_pkg::TILT_ENTER_RESET;
      leave_q <= tsrgd_pkg::TILT_LEAVE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsrgd_pkg::CFG_CAL_X:      cal_q[0]    <= cfg_wdata_i;
        tsrgd_pkg::CFG_CAL_Y:      cal_q[1]    <= cfg_wdata_i;
        tsrgd_pkg::CFG_CAL_Z:      cal_q[2]    <= cfg_wdata_i;
        tsrgd_pkg::CFG_SHAKE_X:    bounds_q[0] <= cfg_wdata_i[15:0];
        tsrgd_pkg::CFG_SHAKE_Y:    bounds_q[1] <= cfg_wdata_i[15:0];
        tsrgd_pkg::CFG_SHAKE_Z:    bounds_q[2] <= cfg_wdata_i[15:0];
        tsrgd_pkg::CFG_TILT_ENTER: enter_q     <= cfg_wdata_i[6:0];
        tsrgd_pkg::CFG_TILT_LEAVE: leave_q     <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  tsrgd_pkg::seq_state_e state_q, state_d;
  logic [1:0] ax_q;
  logic [2:0] bit_q;
  logic       in_acc;
  logic       emit;
  logic       out_valid_q;

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsrgd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    emit       = 1'b0;
    unique case (state_q)
      tsrgd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = tsrgd_pkg::ST_LOAD;
      end
      tsrgd_pkg::ST_LOAD: state_d = tsrgd_pkg::ST_DIV;
      tsrgd_pkg::ST_DIV: begin
        if (bit_q == 3'd0) state_d = tsrgd_pkg::ST_UPDATE;
      end
      tsrgd_pkg::ST_UPDATE: begin
        state_d = (ax_q == tsrgd_pkg::AXIS_Z) ? tsrgd_pkg::ST_EMIT : tsrgd_pkg::ST_LOAD;
      end
      tsrgd_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit    = 1'b1;
          state_d = tsrgd_pkg::ST_IDLE;
        end
      end
      default: state_d = tsrgd_pkg::ST_IDLE;
    endcase
  end

  // Axis counter and divider step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q  <= tsrgd_pkg::AXIS_X;
      bit_q <= '0;
    end else begin
      if (in_acc) ax_q <= tsrgd_pkg::AXIS_X;
      else if (state_q == tsrgd_pkg::ST_UPDATE) ax_q <= ax_q + 2'd1;
      if (state_q == tsrgd_pkg::ST_LOAD) bit_q <= 3'd7;
      else if (state_q == tsrgd_pkg::ST_DIV) bit_q <= bit_q - 3'd1;
    end
  end

  // Captured sample
  tsrgd_pkg::in_word_t in_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_word_i;
  end

  // Load: clamp, offset and scale numerator for the current axis
  logic signed [15:0] raw_sel;
  logic [31:0]        cal_sel;
  logic signed [15:0] cal_lo, cal_hi, raw_clamp;
  logic signed [16:0] diff17, span17;
  logic [23:0]        num;
  logic               degen;

  always_comb begin
    case (ax_q)
      tsrgd_pkg::AXIS_X: raw_sel = in_q.raw_x;
      tsrgd_pkg::AXIS_Y: raw_sel = in_q.raw_y;
      default:           raw_sel = in_q.raw_z;
    endcase
    cal_sel   = (ax_q == tsrgd_pkg::AXIS_X) ? cal_q[0] :
                (ax_q == tsrgd_pkg::AXIS_Y) ? cal_q[1] : cal_q[2];
    cal_lo    = $signed(cal_sel[15:0]);
    cal_hi    = $signed(cal_sel[31:16]);
    degen     = (cal_hi <= cal_lo);
    raw_clamp = (raw_sel < cal_lo) ? cal_lo : ((raw_sel > cal_hi) ? cal_hi : raw_sel);
    diff17    = {raw_clamp[15], raw_clamp} - {cal_lo[15], cal_lo};
    span17    = {cal_hi[15], cal_hi} - {cal_lo[15], cal_lo};
    num       = diff17[15:0] * tsrgd_pkg::SCALE_SPAN;
  end

  // Shared restoring divider, one quotient bit per cycle
  logic [23:0] rem_q;
  logic [22:0] dsh_q;
  logic [7:0]  quo_q;
  logic        degen_q;
  logic        ge;

  assign ge = (rem_q >= {1'b0, dsh_q});

  always_ff @(posedge clk_i) begin
    if (state_q == tsrgd_pkg::ST_LOAD) begin
      rem_q   <= num;
      dsh_q   <= {span17[15:0], 7'd0};
      quo_q   <= '0;
      degen_q <= degen;
    end else if (state_q == tsrgd_pkg::ST_DIV) begin
      rem_q <= ge ? (rem_q - {1'b0, dsh_q}) : rem_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[6:0], ge};
    end
  end

  // Update: scaled value, average, tilt, roll and shake for the current axis
  tsrgd_pkg::tilt_e   tilt_q[3];
  logic signed [7:0]  avg_q [3];
  logic [SLOT_W-1:0]  slots_q;
  logic [CNT_W-1:0]   count_q;
  logic [31:0]        last_roll_q, last_shake_q;
  logic signed [7:0]  sc_q  [3];
  logic [2:0]         tnew_q, tpos_q;
  logic               shake_q, ready_q;

  logic signed [8:0]  s9;
  logic signed [7:0]  s;
  logic [7:0]         mag;
  logic signed [7:0]  avg_old;
  logic signed [11:0] old12, sum12, neg12;
  logic [10:0]        sum_mag;
  logic [23:0]        prod;
  logic [7:0]         quot10;
  logic signed [7:0]  avg_new;
  tsrgd_pkg::tilt_e   tilt_cur;
  logic               tilt_enter, tilt_leave;
  logic               roll_expired;
  logic [SLOT_W-1:0]  slots_base, slots_new;
  logic [CNT_W-1:0]   count_base, count_new;
  logic [1:0]         axis_code;
  logic [15:0]        bnd_sel;
  logic signed [7:0]  bnd_lo, bnd_hi;
  logic               shake_open, shake_hit;

  always_comb begin
    s9        = degen_q ? -tsrgd_pkg::SCALE_OFFSET
                        : ($signed({1'b0, quo_q}) - tsrgd_pkg::SCALE_OFFSET);
    s         = s9[7:0];
    mag       = s[7] ? 8'(-s) : 8'(s);

    // (9 * old + s) / 10, toward zero
    avg_old   = (ax_q == tsrgd_pkg::AXIS_X) ? avg_q[0] :
                (ax_q == tsrgd_pkg::AXIS_Y) ? avg_q[1] : avg_q[2];
    old12     = {{4{avg_old[7]}}, avg_old};
    sum12     = (old12 <<< 3) + old12 + {{4{s[7]}}, s};
    neg12     = -sum12;
    sum_mag   = sum12[11] ? neg12[10:0] : sum12[10:0];
    prod      = sum_mag * tsrgd_pkg::RECIP10;
    quot10    = prod[tsrgd_pkg::RECIP10_SHIFT +: 8];
    avg_new   = sum12[11] ? 8'(-quot10) : quot10;

    // Tilt with hysteresis
    tilt_cur   = (ax_q == tsrgd_pkg::AXIS_X) ? tilt_q[0] :
                 (ax_q == tsrgd_pkg::AXIS_Y) ? tilt_q[1] : tilt_q[2];
    tilt_enter = (mag > {1'b0, enter_q}) && (tilt_cur == tsrgd_pkg::TILT_LEVEL);
    tilt_leave = (mag < {1'b0, leave_q}) && (tilt_cur != tsrgd_pkg::TILT_LEVEL);

    // Roll pattern, emptied after the timeout
    roll_expired = ((in_q.now_ms - last_roll_q) > tsrgd_pkg::ROLL_TIMEOUT_MS);
    slots_base   = roll_expired ? '0 : slots_q;
    count_base   = roll_expired ? '0 : count_q;
    axis_code    = ax_q + 2'd1;
    slots_new    = {slots_base[SLOT_W-3:0], axis_code};
    count_new    = (count_base < CNT_W'(ROLL_DEPTH)) ? count_base + 1'b1 : count_base;

    // Shake bounds test with hold-off
    bnd_sel    = (ax_q == tsrgd_pkg::AXIS_X) ? bounds_q[0] :
                 (ax_q == tsrgd_pkg::AXIS_Y) ? bounds_q[1] : bounds_q[2];
    bnd_lo     = $signed(bnd_sel[7:0]);
    bnd_hi     = $signed(bnd_sel[15:8]);
    shake_open = ((in_q.now_ms - last_shake_q) >= tsrgd_pkg::SHAKE_HOLDOFF_MS);
    shake_hit  = shake_open && ((s < bnd_lo) || (s > bnd_hi));
  end

  // Detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        tilt_q[i] <= tsrgd_pkg::TILT_LEVEL;
        avg_q[i]  <= '0;
      end
      slots_q      <= '0;
      count_q      <= '0;
      last_roll_q  <= '0;
      last_shake_q <= '0;
      tnew_q       <= '0;
      tpos_q       <= '0;
      shake_q      <= 1'b0;
      ready_q      <= 1'b0;
    end else if (in_acc) begin
      if (in_word_i.clear_roll) begin
        slots_q <= '0;
        count_q <= '0;
      end
      tnew_q  <= '0;
      tpos_q  <= '0;
      shake_q <= 1'b0;
      ready_q <= 1'b0;
    end else if (state_q == tsrgd_pkg::ST_UPDATE) begin
      avg_q[ax_q] <= avg_new;
      if (tilt_enter) begin
        tilt_q[ax_q] <= s9 > 9'sd0 ? tsrgd_pkg::TILT_POS : tsrgd_pkg::TILT_NEG;
        tnew_q[ax_q] <= 1'b1;
        tpos_q[ax_q] <= (s9 > 9'sd0);
        slots_q      <= slots_new;
        count_q      <= count_new;
        last_roll_q  <= in_q.now_ms;
        if (count_new > CNT_W'(tsrgd_pkg::ROLL_READY_LEN)) ready_q <= 1'b1;
      end else if (tilt_leave) begin
        tilt_q[ax_q] <= tsrgd_pkg::TILT_LEVEL;
      end
      if (shake_hit) begin
        shake_q      <= 1'b1;
        last_shake_q <= in_q.now_ms;
      end
    end
  end

  // Scaled values of this word
  always_ff @(posedge clk_i) begin
    if (state_q == tsrgd_pkg::ST_UPDATE) sc_q[ax_q] <= s;
  end

  // Output register
  tsrgd_pkg::out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.scaled_x      <= sc_q[0];
      out_q.scaled_y      <= sc_q[1];
      out_q.scaled_z      <= sc_q[2];
      out_q.avg_x         <= avg_q[0];
      out_q.avg_y         <= avg_q[1];
      out_q.avg_z         <= avg_q[2];
      out_q.tilt_new      <= tnew_q;
      out_q.tilt_positive <= tpos_q;
      out_q.shake_seen    <= shake_q;
      out_q.roll_pattern  <= 16'(slots_q);
      out_q.roll_length   <= 4'(count_q);
      out_q.roll_ready    <= ready_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  `TSRGD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accept did not start work")
  `TSRGD_ASSERT_NOW(a_pos_only_new, out_valid_o, (out_word_o.tilt_positive & ~out_word_o.tilt_new) == 3'd0, "tilt sign without new tilt")
  `TSRGD_ASSERT_NOW(a_ready_needs_tilt, out_valid_o && out_word_o.roll_ready, out_word_o.tilt_new != 3'd0, "roll ready without tilt")
  `TSRGD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(ROLL_DEPTH), "roll count above depth")

endmodule

// ===== sim/tilt_shake_roll_gesture_detector_unit_test.sv =====
// Self-checking testbench for the tilt, shake and roll gesture detector.
module tilt_shake_roll_gesture_detector_unit_test;

  localparam int ROLL_SLOTS = 8;

  // Random idle patterns of the two channels
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // Mirror of the detector: registers, gesture state and the predicted words
  class gesture_scoreboard;
    logic [31:0] cal_range [3];
    logic [15:0] shake_bounds [3];
    logic [6:0] enter_level;
    logic [6:0] leave_level;
    tsrgd_pkg::tilt_e tilt_state [3];
    int avg_val [3];
    logic [2*ROLL_SLOTS-1:0] roll_slots;
    int roll_count;
    logic [31:0] last_roll_ms;
    logic [31:0] last_shake_ms;
    tsrgd_pkg::out_word_t predicted_words [$];
    int error_count;
    int results_seen;

    function new();
      for (int ax = 0; ax < 3; ax++) begin
        cal_range[ax] = tsrgd_pkg::CAL_RESET;
        shake_bounds[ax] = tsrgd_pkg::SHAKE_RESET;
        tilt_state[ax] = tsrgd_pkg::TILT_LEVEL;
        avg_val[ax] = 0;
      end
      enter_level = tsrgd_pkg::TILT_ENTER_RESET;
      leave_level = tsrgd_pkg::TILT_LEAVE_RESET;
      roll_slots = '0;
      roll_count = 0;
      last_roll_ms = '0;
      last_shake_ms = '0;
      error_count = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        tsrgd_pkg::CFG_CAL_X: cal_range[0] = data;
        tsrgd_pkg::CFG_CAL_Y: cal_range[1] = data;
        tsrgd_pkg::CFG_CAL_Z: cal_range[2] = data;
        tsrgd_pkg::CFG_SHAKE_X: shake_bounds[0] = data[15:0];
        tsrgd_pkg::CFG_SHAKE_Y: shake_bounds[1] = data[15:0];
        tsrgd_pkg::CFG_SHAKE_Z: shake_bounds[2] = data[15:0];
        tsrgd_pkg::CFG_TILT_ENTER: enter_level = data[6:0];
        tsrgd_pkg::CFG_TILT_LEAVE: leave_level = data[6:0];
        default: ;
      endcase
    endfunction

    // Clamp to the calibrated range, then map onto -127..123
    function int scale_axis(logic [15:0] raw, logic [31:0] cal);
      int lo;
      int hi;
      int v;
      lo = $signed(cal[15:0]);
      hi = $signed(cal[31:16]);
      v = $signed(raw);
      if (hi <= lo) return -127;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return ((v - lo) * 250) / (hi - lo) - 127;
    endfunction

    // Advance the gesture state by one accepted word and queue its result
    function void note_sample(tsrgd_pkg::in_word_t w);
      tsrgd_pkg::out_word_t r;
      logic [15:0] raw [3];
      int s [3];
      int mag;
      int blo;
      int bhi;
      logic [2:0] tnew;
      logic [2:0] tpos;
      logic shake;
      logic ready;
      logic [31:0] now;
      raw[0] = w.raw_x;
      raw[1] = w.raw_y;
      raw[2] = w.raw_z;
      now = w.now_ms;
      tnew = '0;
      tpos = '0;
      shake = 1'b0;
      ready = 1'b0;
      if (w.clear_roll) begin
        roll_slots = '0;
        roll_count = 0;
      end
      for (int ax = 0; ax < 3; ax++) begin
        s[ax] = scale_axis(raw[ax], cal_range[ax]);
        mag = s[ax] < 0 ? -s[ax] : s[ax];
        avg_val[ax] = (9 * avg_val[ax] + s[ax]) / 10;
        // tilt with hysteresis; a fresh tilt feeds the roll pattern
        if (mag > int'(enter_level) && tilt_state[ax] == tsrgd_pkg::TILT_LEVEL) begin
          tilt_state[ax] = s[ax] > 0 ? tsrgd_pkg::TILT_POS : tsrgd_pkg::TILT_NEG;
          tnew[ax] = 1'b1;
          if (s[ax] > 0) tpos[ax] = 1'b1;
          if (now - last_roll_ms > tsrgd_pkg::ROLL_TIMEOUT_MS) begin
            roll_slots = '0;
            roll_count = 0;
          end
          roll_slots = (roll_slots << 2) | (2*ROLL_SLOTS)'(ax + 1);
          if (roll_count < ROLL_SLOTS) roll_count++;
          last_roll_ms = now;
          if (roll_count > tsrgd_pkg::ROLL_READY_LEN) ready = 1'b1;
        end else if (mag < int'(leave_level) && tilt_state[ax] != tsrgd_pkg::TILT_LEVEL) begin
          tilt_state[ax] = tsrgd_pkg::TILT_LEVEL;
        end
        // shake test, held off after the last shake
        if (now - last_shake_ms >= tsrgd_pkg::SHAKE_HOLDOFF_MS) begin
          blo = $signed(shake_bounds[ax][7:0]);
          bhi = $signed(shake_bounds[ax][15:8]);
          if (s[ax] < blo || s[ax] > bhi) begin
            shake = 1'b1;
            last_shake_ms = now;
          end
        end
      end
      r.scaled_x = 8'(s[0]);
      r.scaled_y = 8'(s[1]);
      r.scaled_z = 8'(s[2]);
      r.avg_x = 8'(avg_val[0]);
      r.avg_y = 8'(avg_val[1]);
      r.avg_z = 8'(avg_val[2]);
      r.tilt_new = tnew;
      r.tilt_positive = tpos;
      r.shake_seen = shake;
      r.roll_pattern = 16'(roll_slots);
      r.roll_length = 4'(roll_count);
      r.roll_ready = ready;
      predicted_words.push_back(r);
    endfunction

    function void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= 10)
        $display("result %0d, %s: expected %h, got %h", results_seen, field, want, got);
    endfunction

    function void check_result(tsrgd_pkg::out_word_t got);
      tsrgd_pkg::out_word_t want;
      results_seen++;
      if (predicted_words.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("result %0d arrived with no word pending", results_seen);
        return;
      end
      want = predicted_words.pop_front();
      if (got.scaled_x !== want.scaled_x) note_mismatch("scaled_x", want.scaled_x, got.scaled_x);
      if (got.scaled_y !== want.scaled_y) note_mismatch("scaled_y", want.scaled_y, got.scaled_y);
      if (got.scaled_z !== want.scaled_z) note_mismatch("scaled_z", want.scaled_z, got.scaled_z);
      if (got.avg_x !== want.avg_x) note_mismatch("avg_x", want.avg_x, got.avg_x);
      if (got.avg_y !== want.avg_y) note_mismatch("avg_y", want.avg_y, got.avg_y);
      if (got.avg_z !== want.avg_z) note_mismatch("avg_z", want.avg_z, got.avg_z);
      if (got.tilt_new !== want.tilt_new) note_mismatch("tilt_new", want.tilt_new, got.tilt_new);
      if (got.tilt_positive !== want.tilt_positive)
        note_mismatch("tilt_positive", want.tilt_positive, got.tilt_positive);
      if (got.shake_seen !== want.shake_seen)
        note_mismatch("shake_seen", want.shake_seen, got.shake_seen);
      if (got.roll_pattern !== want.roll_pattern)
        note_mismatch("roll_pattern", want.roll_pattern, got.roll_pattern);
      if (got.roll_length !== want.roll_length)
        note_mismatch("roll_length", want.roll_length, got.roll_length);
      if (got.roll_ready !== want.roll_ready)
        note_mismatch("roll_ready", want.roll_ready, got.roll_ready);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  tsrgd_pkg::in_word_t in_word = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  tsrgd_pkg::out_word_t out_word_o;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = tsrgd_pkg::CFG_CAL_X;
  logic [31:0] cfg_wdata = '0;

  gesture_scoreboard sb = new();
  idle_mode_e idle_mode = IDLE_NONE;
  idle_mode_e phase_modes [4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
  logic [31:0] now_clock = '0;

  tilt_shake_roll_gesture_detector_unit #(
    .ROLL_DEPTH(ROLL_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 86;
      IDLE_BOTH: return $urandom_range(0, 99) < 35;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 86;
      IDLE_BOTH: return $urandom_range(0, 99) < 35;
      default: return 1'b0;
    endcase
  endfunction

  // Receiver: stall changes on the falling edge, words are taken on the rising one
  always @(negedge clk_i) begin
    out_stall <= receiver_stalls();
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) sb.check_result(out_word_o);
  end

  // Offer one word, with random gaps ahead, and hold it until taken
  task automatic send_word(input tsrgd_pkg::in_word_t w);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(w);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    sb.write_reg(idx, data);
  endtask

  function automatic tsrgd_pkg::in_word_t make_word(int x, int y, int z, logic [31:0] t,
                                                   bit clr);
    tsrgd_pkg::in_word_t w;
    w.raw_x = 16'(x);
    w.raw_y = 16'(y);
    w.raw_z = 16'(z);
    w.now_ms = t;
    w.clear_roll = clr;
    return w;
  endfunction

  function automatic logic [31:0] random_cal();
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (r < 20) return tsrgd_pkg::CAL_RESET;
    lo = int'($urandom_range(0, 40000)) - 32768;
    if (r < 30) hi = lo + int'($urandom_range(1, 10));
    else hi = lo + int'($urandom_range(1, 32767 - lo));
    if (hi > 32767) hi = 32767;
    return {16'(hi), 16'(lo)};
  endfunction

  function automatic logic [15:0] random_bounds();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'($urandom);
    if (r < 25) return tsrgd_pkg::SHAKE_RESET;
    return {8'($urandom_range(20, 123)), 8'(-int'($urandom_range(20, 127)))};
  endfunction

  // Register set of one phase; two phases hold the corner settings
  task automatic apply_setting(input int phase);
    logic [31:0] cal [3];
    logic [15:0] bounds [3];
    logic [6:0] enter_lv;
    logic [6:0] leave_lv;
    case (phase)
      2: begin
        // empty range, inverted range, one-step range; shake always / inverted
        cal[0] = 32'h0000_0000;
        cal[1] = 32'h8000_7FFF;
        cal[2] = 32'h0001_0000;
        bounds[0] = 16'h0000;
        bounds[1] = 16'hFFFF;
        bounds[2] = 16'h807F;
        enter_lv = 7'd0;
        leave_lv = 7'd127;
      end
      3: begin
        cal[0] = 32'hFFFF_FFFF;
        cal[1] = tsrgd_pkg::CAL_RESET;
        cal[2] = 32'h7FFF_7FFE;
        bounds[0] = 16'h7F80;
        bounds[1] = 16'h0000;
        bounds[2] = random_bounds();
        enter_lv = 7'd127;
        leave_lv = 7'd0;
      end
      default: begin
        for (int ax = 0; ax < 3; ax++) begin
          cal[ax] = random_cal();
          bounds[ax] = random_bounds();
        end
        enter_lv = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(40, 120));
        leave_lv = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(0, 60));
      end
    endcase
    write_cfg(tsrgd_pkg::CFG_CAL_X, cal[0]);
    write_cfg(tsrgd_pkg::CFG_CAL_Y, cal[1]);
    write_cfg(tsrgd_pkg::CFG_CAL_Z, cal[2]);
    write_cfg(tsrgd_pkg::CFG_SHAKE_X, {16'h0, bounds[0]});
    write_cfg(tsrgd_pkg::CFG_SHAKE_Y, {16'h0, bounds[1]});
    write_cfg(tsrgd_pkg::CFG_SHAKE_Z, {16'h0, bounds[2]});
    write_cfg(tsrgd_pkg::CFG_TILT_ENTER, {25'h0, enter_lv});
    write_cfg(tsrgd_pkg::CFG_TILT_LEAVE, {25'h0, leave_lv});
    cfg_we <= 1'b0;
  endtask

  // Raw value aimed at the calibrated range: level, near either end, past it, or anywhere
  function automatic logic [15:0] pick_raw(logic [31:0] cal);
    int lo;
    int hi;
    int span;
    int v;
    int r;
    lo = $signed(cal[15:0]);
    hi = $signed(cal[31:16]);
    r = $urandom_range(0, 99);
    if (hi <= lo || r >= 90) return 16'($urandom);
    span = hi - lo;
    if (r < 35) v = lo + span / 2 + int'($urandom_range(0, span / 8)) - span / 16;
    else if (r < 55) v = hi - int'($urandom_range(0, span / 16));
    else if (r < 75) v = lo + int'($urandom_range(0, span / 16));
    else if (r < 83) v = hi + int'($urandom_range(1, 2000));
    else v = lo - int'($urandom_range(1, 2000));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Mostly short time steps so tilts chain into rolls; some at the timing edges
  function automatic tsrgd_pkg::in_word_t random_word();
    tsrgd_pkg::in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      case ($urandom_range(0, 3))
        0: now_clock += 32'd499;
        1: now_clock += 32'd500;
        2: now_clock += 32'd2000;
        default: now_clock += 32'd2001;
      endcase
    end else if (r < 80) begin
      now_clock += $urandom_range(0, 450);
    end else if (r < 95) begin
      now_clock += $urandom_range(1500, 3000);
    end else begin
      now_clock = $urandom;
    end
    w.raw_x = pick_raw(sb.cal_range[0]);
    w.raw_y = pick_raw(sb.cal_range[1]);
    w.raw_z = pick_raw(sb.cal_range[2]);
    w.now_ms = now_clock;
    w.clear_roll = $urandom_range(0, 99) < 5;
    return w;
  endfunction

  // Directed words at reset settings: tilt chains, roll saturation and readiness,
  // roll timeout, clear request, timestamp wrap, tilt thresholds
  task automatic run_directed();
    send_word(make_word(0, 0, 0, 0, 0));
    send_word(make_word(32767, 0, 0, 100, 0));
    send_word(make_word(32767, -32768, 0, 200, 0));
    send_word(make_word(0, 0, 32767, 300, 0));
    send_word(make_word(-32768, 0, 0, 400, 0));
    send_word(make_word(0, 32767, 0, 500, 0));
    send_word(make_word(32767, 0, 32767, 600, 0));
    send_word(make_word(0, 0, 0, 700, 0));
    send_word(make_word(-32768, -32768, -32768, 800, 0));
    send_word(make_word(0, 0, 0, 900, 0));
    send_word(make_word(32767, 0, 0, 3000, 0));
    send_word(make_word(0, 0, 0, 3100, 0));
    send_word(make_word(32767, 0, 0, 3200, 1));
    send_word(make_word(0, 0, 0, 3300, 1));
    send_word(make_word(32767, 0, 0, 32'hFFFF_FE00, 0));
    send_word(make_word(0, 0, 0, 32'hFFFF_FF00, 0));
    send_word(make_word(0, 32767, 0, 32'h0000_0100, 0));
    send_word(make_word(25951, 0, 0, 32'h0000_0200, 0));
    send_word(make_word(25952, 0, 0, 32'h0000_0300, 0));
    send_word(make_word(8913, 0, 0, 32'h0000_0400, 0));
    send_word(make_word(8912, -1, 1, 32'h0000_0500, 0));
    now_clock = 32'h0000_0500;
  endtask

  // Run limit
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      idle_mode <= phase_modes[phase % 4];
      if (phase > 0) apply_setting(phase);
      else run_directed();
      repeat (250) send_word(random_word());
      in_valid <= 1'b0;
      while (sb.predicted_words.size() != 0) @(negedge clk_i);
    end
    // let any stray word show up
    repeat (40) @(negedge clk_i);
    if (sb.error_count == 0 && sb.predicted_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== tilt_shake_roll_gesture_detector_unit.f =====
+incdir+hw/rtl
hw/rtl/tsrgd_pkg.sv
hw/rtl/tilt_shake_roll_gesture_detector_unit.sv
sim/tilt_shake_roll_gesture_detector_unit_test.sv
